[rtl/core/onewire_temperature_frame_decoder_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the scratchpad frame decoder
// Shared property forms; clk and arst_n are taken from the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef ONEWIRE_TEMPERATURE_FRAME_DECODER_MACROS_SVH
`define ONEWIRE_TEMPERATURE_FRAME_DECODER_MACROS_SVH

// same-cycle implication
`define OWTFD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("owtfd assertion failed");

// next-cycle implication
`define OWTFD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("owtfd assertion failed");

`endif

[rtl/core/owtfd_pkg.sv]
// ----------------------------------------------------------------------------
// owtfd_pkg
// Constants, types and the CRC8 byte update for the scratchpad frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package owtfd_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned PosW   = 4;
	localparam int unsigned RawW   = 16;
	localparam int unsigned TempW  = 19;

	localparam logic [PosW-1:0]  FrameLast   = 4'd8;
	localparam logic [ByteW-1:0] CrcPoly     = 8'h8C;
	localparam logic [ByteW-1:0] FamFine     = 8'h28;
	localparam logic [ByteW-1:0] FamFineAlt  = 8'h22;
	localparam logic [ByteW-1:0] FamHalfDeg  = 8'h10;
	localparam logic signed [TempW-1:0] UnknownTemp = 19'sd16000;

	typedef logic [ByteW-1:0]        byte_t;
	typedef logic [PosW-1:0]         pos_t;
	typedef logic signed [RawW-1:0]  raw_t;
	typedef logic signed [TempW-1:0] temp_t;

	function automatic byte_t crc8_byte(input byte_t crc_in, input byte_t data);
		byte_t crc;
		logic  fb;
		crc = crc_in;
		for (int b = 0; b < ByteW; b++) begin
			fb  = crc[0] ^ data[b];
			crc = {1'b0, crc[ByteW-1:1]};
			if (fb) begin
				crc = crc ^ CrcPoly;
			end
		end
		return crc;
	endfunction

endpackage

`default_nettype wire

[rtl/core/onewire_temperature_frame_decoder.sv]
// ----------------------------------------------------------------------------
// onewire_temperature_frame_decoder
// Decodes a nine-byte sensor scratchpad into a checked temperature result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one scratchpad byte per beat, byte 0
//   first; family_code is sampled only with byte 0 of a frame.
//   Output channel (out_valid/out_ready): one result beat per nine input
//   beats, carrying the CRC8 check, the scaled temperature in 1/16 degree,
//   the known-family flag and the raw reading.
//   Throughput: one input beat per cycle unless a ninth byte waits on an
//   untaken result. The CRC8 byte update is eight unrolled XOR steps between
//   the input stage and the frame state. Result path: byte 8 is registered
//   in the input stage, then loaded into the result register.
//   Reset: clears the input stage, the output register and the frame state,
//   so the next beat is taken as byte 0.
//   Stall: while a result waits, bytes 0 to 7 of the next frame keep flowing;
//   only a ninth byte holds in the input stage until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module onewire_temperature_frame_decoder (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [owtfd_pkg::ByteW-1:0]         scratch_byte,
	input  wire logic [owtfd_pkg::ByteW-1:0]         family_code,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [owtfd_pkg::TempW-1:0]       temperature_sixteenths,
	output logic                                     crc_ok,
	output logic                                     sensor_known,
	output logic signed [owtfd_pkg::RawW-1:0]        raw_reading
);

	logic              valid_s1;
	owtfd_pkg::byte_t  byte_s1;
	owtfd_pkg::byte_t  family_s1;

	owtfd_pkg::pos_t   pos_q;
	owtfd_pkg::byte_t  crc_q;
	owtfd_pkg::raw_t   reading_q;
	owtfd_pkg::byte_t  family_q;

	logic              out_valid_q;
	owtfd_pkg::temp_t  temp_q;
	logic              crc_ok_q;
	logic              known_q;
	owtfd_pkg::raw_t   raw_q;

	logic              last_s1;
	logic              out_free;
	logic              adv_s1;
	logic              load_out;
	owtfd_pkg::byte_t  crc_next;
	owtfd_pkg::byte_t  fam_eff;
	owtfd_pkg::temp_t  temp_next;
	logic              known_next;

	assign last_s1  = (pos_q == owtfd_pkg::FrameLast);
	assign out_free = !out_valid_q || out_ready;
	assign adv_s1   = valid_s1 && (!last_s1 || out_free);
	assign load_out = adv_s1 && last_s1;
	assign in_ready = !valid_s1 || adv_s1;
	assign crc_next = owtfd_pkg::crc8_byte(crc_q, byte_s1);
	assign fam_eff  = family_q;

	always_comb begin
		known_next = 1'b1;
		case (fam_eff) inside
			owtfd_pkg::FamFine, owtfd_pkg::FamFineAlt: begin
				temp_next = owtfd_pkg::TempW'(reading_q);
			end
			owtfd_pkg::FamHalfDeg: begin
				temp_next = owtfd_pkg::TempW'(reading_q) <<< 3;
			end
			default: begin
				temp_next  = owtfd_pkg::UnknownTemp;
				known_next = 1'b0;
			end
		endcase
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1   <= scratch_byte;
			family_s1 <= family_code;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			crc_q     <= '0;
			reading_q <= '0;
			family_q  <= '0;
		end else if (adv_s1) begin
			if (last_s1) begin
				pos_q     <= '0;
				crc_q     <= '0;
				reading_q <= '0;
				family_q  <= '0;
			end else begin
				pos_q <= pos_q + owtfd_pkg::pos_t'(1);
				crc_q <= crc_next;
				if (pos_q == '0) begin
					family_q        <= family_s1;
					reading_q[7:0]  <= byte_s1;
				end else if (pos_q == owtfd_pkg::pos_t'(1)) begin
					reading_q[15:8] <= byte_s1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			temp_q   <= temp_next;
			crc_ok_q <= (crc_next == '0);
			known_q  <= known_next;
			raw_q    <= reading_q;
		end
	end

	assign out_valid              = out_valid_q;
	assign temperature_sixteenths = temp_q;
	assign crc_ok                 = crc_ok_q;
	assign sensor_known           = known_q;
	assign raw_reading            = raw_q;

endmodule

`default_nettype wire

[rtl/core/owtfd_checker.sv]
// ----------------------------------------------------------------------------
// owtfd_checker
// Port-level checks for the scratchpad frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "onewire_temperature_frame_decoder_macros.svh"

module owtfd_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                in_valid,
	input wire logic                                in_ready,
	input wire logic [owtfd_pkg::ByteW-1:0]         scratch_byte,
	input wire logic [owtfd_pkg::ByteW-1:0]         family_code,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic signed [owtfd_pkg::TempW-1:0]  temperature_sixteenths,
	input wire logic                                crc_ok,
	input wire logic                                sensor_known,
	input wire logic signed [owtfd_pkg::RawW-1:0]   raw_reading
);

	`OWTFD_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(scratch_byte) && $stable(family_code))
	`OWTFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(temperature_sixteenths) && $stable(crc_ok) && $stable(sensor_known) && $stable(raw_reading))
	`OWTFD_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)
	`OWTFD_ASSERT_NOW(a_unknown_temp, out_valid && !sensor_known, temperature_sixteenths == owtfd_pkg::UnknownTemp)
	`OWTFD_ASSERT_NOW(a_known_scale, out_valid && sensor_known, (temperature_sixteenths == raw_reading) || (temperature_sixteenths == raw_reading * 8))

endmodule

bind onewire_temperature_frame_decoder owtfd_checker u_owtfd_checker (.*);

`default_nettype wire
